// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/fpba_pkg.sv =====
// Types and constants of the fit-policy block allocator.
package fpba_pkg;

   localparam int BLOCKS     = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(BLOCKS);
   localparam int COUNT_BITS = 5;
   localparam int REQ_BITS   = 16;
   localparam int CSR_BITS   = 5;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic CSR_FIT_MODE    = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RESET = COUNT_BITS'(16);

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   typedef struct packed {
      logic                action;
      logic [3:0]          block_index;
      logic [REQ_BITS-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic [3:0] granted_block;
   } rsp_type;

   typedef struct packed {
      logic     found;
      size_type size;
   } pick_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

endpackage

// ===== rtl/core/fpba_select.sv =====
// Fit-policy decision for one scanned block against the current pick.
module fpba_select (
   input  logic [1:0]                    fit_mode,
   input  fpba_pkg::pick_type            best,
   input  fpba_pkg::size_type            cand_size,
   input  logic [fpba_pkg::REQ_BITS-1:0] req_size,
   output logic                          take
);

   logic fits;
   logic better;

   always_comb begin
      fits = (fpba_pkg::REQ_BITS'(cand_size) >= req_size);
      case (fit_mode)
         fpba_pkg::FIT_BEST:  better = (cand_size < best.size);
         fpba_pkg::FIT_WORST: better = (cand_size > best.size);
         default:             better = 1'b0;
      endcase
      take = fits && (!best.found || better);
   end

endmodule

// ===== rtl/core/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator: size memory, scan sequencer, result register.
//
// Usage: raise start with a word on req_word while busy is low; the word is
// taken at that edge. A load word (action 0) writes one block's free size in
// the same edge, gives no result and leaves busy low, so loads may follow
// every cycle. A request word (action 1) raises busy and scans blocks 0 to
// n-1 (n is block_count, capped at 16) by reading the size memory one entry
// per cycle; each read is registered and judged against the running pick
// in the next cycle. Drain and update states follow, the update writing
// the reduced size back. Busy stays high through scan, drain and update;
// the next word is taken on the cycle busy falls. The result word shows on
// rsp_word for one cycle with rsp_strobe high, in the same cycle that busy
// falls. With block_count 0 the scan is skipped: busy is high for one cycle
// and the result shows in the cycle busy falls.
// Results cannot be stalled.
// csr_we writes fit_mode (index 0) or block_count (index 1) at once; write
// them only while idle. Reset returns to idle, first fit, 16 blocks; the
// size memory is not cleared and every block must be loaded before use.
`include "assert_macros.svh"

module fit_policy_block_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fpba_pkg::req_type               req_word,
   output logic                            rsp_strobe,
   output fpba_pkg::rsp_type               rsp_word,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [fpba_pkg::CSR_BITS-1:0]   csr_wdata
);

   fpba_pkg::size_type                    mem [fpba_pkg::BLOCKS];

   fpba_pkg::state_type                   state_ff, state_in;
   logic [1:0]                            fit_mode_ff;
   logic [fpba_pkg::COUNT_BITS-1:0]       block_count_ff;
   logic [fpba_pkg::REQ_BITS-1:0]         req_size_ff, req_size_in;
   fpba_pkg::idx_type                     last_ff, last_in;
   fpba_pkg::idx_type                     addr_ff, addr_in;
   logic                                  rd_valid_ff;
   fpba_pkg::idx_type                     rd_idx_ff;
   fpba_pkg::size_type                    rd_data_ff;
   fpba_pkg::pick_type                    best_ff, best_in;
   fpba_pkg::idx_type                     best_idx_ff, best_idx_in;
   logic                                  rsp_strobe_ff;
   fpba_pkg::rsp_type                     rsp_word_ff, rsp_word_in;

   logic                                  accept;
   logic                                  accept_req;
   logic [fpba_pkg::COUNT_BITS-1:0]       used;
   logic                                  take;
   logic                                  mem_we;
   fpba_pkg::idx_type                     mem_waddr;
   fpba_pkg::size_type                    mem_wdata;

   assign accept     = start && !busy;
   assign accept_req = accept && (req_word.action == fpba_pkg::ACT_REQUEST);
   assign used       = (block_count_ff > fpba_pkg::COUNT_BITS'(fpba_pkg::BLOCKS))
                       ? fpba_pkg::COUNT_BITS'(fpba_pkg::BLOCKS) : block_count_ff;

   fpba_select u_select (
      .fit_mode  (fit_mode_ff),
      .best      (best_ff),
      .cand_size (rd_data_ff),
      .req_size  (req_size_ff),
      .take      (take)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpba_pkg::ST_IDLE: begin
            if (accept_req) begin
               state_in = (used == '0) ? fpba_pkg::ST_UPDATE : fpba_pkg::ST_SCAN;
            end
         end
         fpba_pkg::ST_SCAN: begin
            if (addr_ff == last_ff) begin
               state_in = fpba_pkg::ST_DRAIN;
            end
         end
         fpba_pkg::ST_DRAIN:  state_in = fpba_pkg::ST_UPDATE;
         fpba_pkg::ST_UPDATE: state_in = fpba_pkg::ST_IDLE;
         default:             state_in = fpba_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      busy        = (state_ff != fpba_pkg::ST_IDLE);
      req_size_in = req_size_ff;
      last_in     = last_ff;
      addr_in     = addr_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = req_word.block_index[fpba_pkg::IDX_BITS-1:0];
      mem_wdata   = req_word.size_value[fpba_pkg::SIZE_BITS-1:0];
      rsp_word_in = rsp_word_ff;
      case (state_ff)
         fpba_pkg::ST_IDLE: begin
            if (accept && (req_word.action == fpba_pkg::ACT_LOAD)) begin
               mem_we = 1'b1;
            end
            if (accept_req) begin
               req_size_in   = req_word.size_value;
               last_in       = fpba_pkg::IDX_BITS'(used - 1'b1);
               addr_in       = '0;
               best_in.found = 1'b0;
               best_in.size  = '0;
               best_idx_in   = '0;
            end
         end
         fpba_pkg::ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
         end
         fpba_pkg::ST_UPDATE: begin
            mem_we                    = best_ff.found;
            mem_waddr                 = best_idx_ff;
            mem_wdata                 = fpba_pkg::SIZE_BITS'(best_ff.size - req_size_ff);
            rsp_word_in.granted       = best_ff.found;
            rsp_word_in.granted_block = best_ff.found ? 4'(best_idx_ff) : 4'd0;
         end
         default: begin
         end
      endcase
      if (rd_valid_ff && take) begin
         best_in.found = 1'b1;
         best_in.size  = rd_data_ff;
         best_idx_in   = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fpba_pkg::ST_IDLE;
         fit_mode_ff    <= fpba_pkg::FIT_FIRST;
         block_count_ff <= fpba_pkg::BLOCK_COUNT_RESET;
         rd_valid_ff    <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= (state_ff == fpba_pkg::ST_SCAN);
         rsp_strobe_ff <= (state_ff == fpba_pkg::ST_UPDATE);
         if (csr_we) begin
            case (csr_index)
               fpba_pkg::CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[1:0];
               fpba_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff <= req_size_in;
      last_ff     <= last_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= addr_ff;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   `ASSERT_NEXT(a_req_busy, clock, reset, accept_req, busy)
   `ASSERT_NEXT(a_update_strobe, clock, reset, (state_ff == fpba_pkg::ST_UPDATE), rsp_strobe)
   `ASSERT_IMPLY(a_scan_range, clock, reset, rd_valid_ff, (rd_idx_ff <= last_ff))
   `ASSERT_IMPLY(a_grant_found, clock, reset, (state_ff == fpba_pkg::ST_UPDATE && !best_ff.found), (best_idx_ff == '0))

endmodule

// ===== test/fit_policy_block_allocator_tb.sv =====
// Self-checking testbench for the fit-policy block allocator: loads, fit policies, register settings.
module fit_policy_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FIT_UNUSED  = 2'd3;
   localparam int         PHASES      = 9;
   localparam int         PHASE_WORDS = 145;
   localparam int         SETTLE_PAD  = 30;
   localparam int         CYCLE_LIMIT = 500000;

   class alloc_scoreboard;
      fpba_pkg::size_type free_size [fpba_pkg::BLOCKS];
      logic [1:0]         fit_mode;
      logic [4:0]         block_count;
      fpba_pkg::rsp_type  pending_grants [$];
      int                 errors;
      int                 loads;
      int                 grants;
      int                 refusals;

      function new();
         fit_mode    = fpba_pkg::FIT_FIRST;
         block_count = fpba_pkg::BLOCK_COUNT_RESET;
         errors      = 0;
         loads       = 0;
         grants      = 0;
         refusals    = 0;
      endfunction

      function void write_reg(logic idx, logic [4:0] val);
         if (idx == fpba_pkg::CSR_FIT_MODE) begin
            fit_mode = val[1:0];
         end else begin
            block_count = val;
         end
      endfunction

      function fpba_pkg::rsp_type predict_grant(logic [fpba_pkg::REQ_BITS-1:0] want);
         int                n;
         int                pick;
         int                i;
         fpba_pkg::rsp_type r;
         n    = (block_count > fpba_pkg::BLOCKS) ? fpba_pkg::BLOCKS : int'(block_count);
         pick = -1;
         r    = '0;
         for (i = 0; i < n; i++) begin
            if (free_size[i] >= want) begin
               if (pick < 0) begin
                  pick = i;
                  if (fit_mode != fpba_pkg::FIT_BEST && fit_mode != fpba_pkg::FIT_WORST) break;
               end else if (fit_mode == fpba_pkg::FIT_BEST
                            && free_size[i] < free_size[pick]) begin
                  pick = i;
               end else if (fit_mode == fpba_pkg::FIT_WORST
                            && free_size[i] > free_size[pick]) begin
                  pick = i;
               end
            end
         end
         if (pick >= 0) begin
            free_size[pick]  = free_size[pick] - want;
            r.granted        = 1'b1;
            r.granted_block  = pick[3:0];
            grants++;
         end else begin
            refusals++;
         end
         return r;
      endfunction

      function void note_word(fpba_pkg::req_type w);
         if (w.action == fpba_pkg::ACT_LOAD) begin
            free_size[w.block_index] = w.size_value;
            loads++;
         end else begin
            pending_grants.push_back(predict_grant(w.size_value));
         end
      endfunction

      function void check_word(fpba_pkg::rsp_type got);
         fpba_pkg::rsp_type want;
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %b/%0d",
                     $time, got.granted, got.granted_block);
            errors++;
         end else begin
            want = pending_grants.pop_front();
            if (got.granted !== want.granted) begin
               $display("%0t: granted mismatch, expected %b, got %b",
                        $time, want.granted, got.granted);
               errors++;
            end
            if (got.granted_block !== want.granted_block) begin
               $display("%0t: granted_block mismatch, expected %0d, got %0d",
                        $time, want.granted_block, got.granted_block);
               errors++;
            end
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start;
   logic                          busy;
   fpba_pkg::req_type             req_word;
   logic                          rsp_strobe;
   fpba_pkg::rsp_type             rsp_word;
   logic                          csr_we;
   logic                          csr_index;
   logic [fpba_pkg::CSR_BITS-1:0] csr_wdata;

   alloc_scoreboard sb;
   int              idle_pct;
   int              cycles;
   logic [1:0]      mode_plan  [PHASES];
   logic [4:0]      count_plan [PHASES];

   fit_policy_block_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset) begin
         if (rsp_strobe) sb.check_word(rsp_word);
         if (start && !busy) sb.note_word(req_word);
      end
   end

   function automatic fpba_pkg::req_type make_word(logic act, logic [3:0] idx,
                                                   logic [15:0] sz);
      fpba_pkg::req_type w;
      w.action      = act;
      w.block_index = idx;
      w.size_value  = sz;
      return w;
   endfunction

   task automatic send_word(input fpba_pkg::req_type w);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_grants.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   initial begin
      int                ph;
      int                k;
      int                r;
      logic [15:0]       sz;
      fpba_pkg::req_type w;

      start     <= 1'b0;
      req_word  <= '0;
      csr_we    <= 1'b0;
      csr_index <= fpba_pkg::CSR_FIT_MODE;
      csr_wdata <= '0;
      cycles    <= 0;
      idle_pct   = 0;
      sb         = new();
      mode_plan  = '{fpba_pkg::FIT_BEST, fpba_pkg::FIT_WORST, FIT_UNUSED,
                     fpba_pkg::FIT_FIRST, fpba_pkg::FIT_BEST, fpba_pkg::FIT_WORST,
                     fpba_pkg::FIT_FIRST, fpba_pkg::FIT_BEST, fpba_pkg::FIT_WORST};
      count_plan = '{5'd16, 5'd16, 5'd0, 5'd31, 5'd1, 5'd1, 5'd7, 5'd31, 5'd12};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every block before any request scans it
      for (k = 0; k < fpba_pkg::BLOCKS; k++) begin
         sz = (k == 1) ? 16'hFFFF : 16'((k % 5) * 1500);
         send_word(make_word(fpba_pkg::ACT_LOAD, 4'(k), sz));
      end
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'hF, 16'd0));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'h0, 16'hFFFF));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'h0, 16'hFFFF));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'h5, 16'd1000));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'hA, 16'd3000));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'h3, 16'd6000));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'h3, 16'd6001));
      send_word(make_word(fpba_pkg::ACT_REQUEST, 4'h0, 16'd1));
      settle();

      for (ph = 0; ph < PHASES; ph++) begin
         write_csr(fpba_pkg::CSR_FIT_MODE, {3'b000, mode_plan[ph]});
         write_csr(fpba_pkg::CSR_BLOCK_COUNT, count_plan[ph]);
         idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 72 : 27);
         for (k = 0; k < PHASE_WORDS; k++) begin
            r = $urandom_range(99);
            if (r < 45) begin
               case ($urandom_range(3))
                  0:       sz = 16'($urandom_range(15) * 256);
                  1:       sz = 16'($urandom_range(4095));
                  2:       sz = 16'($urandom);
                  default: sz = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               endcase
               w = make_word(fpba_pkg::ACT_LOAD, 4'($urandom_range(15)), sz);
            end else begin
               r = $urandom_range(99);
               if (r < 70)      sz = 16'($urandom_range(2047));
               else if (r < 80) sz = 16'h0000;
               else if (r < 95) sz = 16'($urandom);
               else             sz = 16'hFFFF;
               w = make_word(fpba_pkg::ACT_REQUEST, 4'($urandom_range(15)), sz);
            end
            send_word(w);
         end
         settle();
      end

      $display("Ran %0d loads and %0d requests (%0d granted, %0d refused)",
               sb.loads, sb.grants + sb.refusals, sb.grants, sb.refusals);
      $display("across first, best, worst and unused fit modes with 0 to 31 blocks set.");
      if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
